### design/dqvs_pkg.sv
// ----------------------------------------------------------------------------
// dqvs_pkg: shared definitions for the deque with value search
// Command codes, status codes and fixed port widths used by the block,
// its checker and its testbench.
// ----------------------------------------------------------------------------
package dqvs_pkg;

    // Fixed field widths of the ports.
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 32;

    // Command codes carried on s_cmd.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_CONTAINS   = 3'd4,
        CMD_REMOVE     = 3'd5
    } dqvs_cmd_t;

    // Status codes reported on m_status.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } dqvs_status_t;

endpackage

### design/deque_with_value_search.sv
// ----------------------------------------------------------------------------
// deque_with_value_search: bounded double-ended queue with value search
// Ring store of CAPACITY signed values, driven by one command word at a time.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one command word (s_cmd, s_value). The m_ channel
//   returns exactly one result word per command: status, found flag, front
//   and back values after the command, and the entry count.
//   Commands are handled one at a time; s_ready is high only while the
//   sequencer is idle, and it returns to idle in the same cycle that its
//   result is loaded into the output register. Every read goes through the
//   single read port of the ring store. A contains compares the entries
//   in order from the front until a match or the back entry; on a match a
//   remove then moves each later entry one place toward the front. After
//   each command the front value and then the back value are read back
//   from the store through the read port. After reset the deque is empty;
//   the store contents are not cleared and no clearing pass is needed. A
//   finished result is held in the output register while the receiver
//   stalls; a new command may be accepted meanwhile, and its result waits
//   until the previous word is taken.
// ----------------------------------------------------------------------------
module deque_with_value_search
    import dqvs_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [CMD_W-1:0]                s_cmd,
    input  logic signed [WORD_W-1:0]        s_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [STATUS_W-1:0]             m_status,
    output logic                            m_found,
    output logic signed [WORD_W-1:0]        m_front_value,
    output logic signed [WORD_W-1:0]        m_back_value,
    output logic [$clog2(CAPACITY+1)-1:0]   m_count
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_EXEC     = 7'b0000010,
        S_SCAN     = 7'b0000100,
        S_SHIFT    = 7'b0001000,
        S_RD_FRONT = 7'b0010000,
        S_RD_BACK  = 7'b0100000,
        S_DONE     = 7'b1000000
    } dqvs_state_t;

    // Ring slot arithmetic, wrapping at CAPACITY.
    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] a);
        return (a == SLOT_W'(CAPACITY - 1)) ? '0 : SLOT_W'(a + 1'b1);
    endfunction

    function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] a);
        return (a == '0) ? SLOT_W'(CAPACITY - 1) : SLOT_W'(a - 1'b1);
    endfunction

    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                   input logic [SLOT_W-1:0] b);
        logic [SLOT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (SLOT_W+1)'(CAPACITY)) begin
            sum = sum - (SLOT_W+1)'(CAPACITY);
        end
        return sum[SLOT_W-1:0];
    endfunction

    // Stored value to 32-bit output word, sign-extended or cut.
    function automatic logic [WORD_W-1:0] to_word(input logic [VALUE_BITS-1:0] v);
        return WORD_W'($signed(v));
    endfunction

    dqvs_state_t state_reg, state_next;
    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    logic [VALUE_BITS-1:0] key_reg, key_next;
    logic [SLOT_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      pos_reg, pos_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic                  found_reg, found_next;
    logic [VALUE_BITS-1:0] front_reg, front_next;

    logic                    m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]     m_status_reg, m_status_next;
    logic                    m_found_reg, m_found_next;
    logic [WORD_W-1:0]       m_front_reg, m_front_next;
    logic [WORD_W-1:0]       m_back_reg, m_back_next;
    logic [CNT_W-1:0]        m_count_reg, m_count_next;

    logic                  mem_we;
    logic [SLOT_W-1:0]     mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic [SLOT_W-1:0]     mem_raddr;
    logic [VALUE_BITS-1:0] mem_rdata;

    logic                  is_empty;
    logic                  is_full;
    logic                  at_last;
    logic [SLOT_W-1:0]     back_slot;

    dqvs_store #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_BITS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // Occupancy flags and the ring slot of the back entry.
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign at_last   = (CNT_W'(pos_reg + 1'b1) >= count_reg);
    assign back_slot = is_empty ? head_reg
                                : slot_add(head_reg, SLOT_W'(count_reg - 1'b1));

    // Sequencer: one command at a time through the shared store read port.
    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        slot_next     = slot_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        front_next    = front_reg;
        m_valid_next  = m_valid_reg & ~m_ready;
        m_status_next = m_status_reg;
        m_found_next  = m_found_reg;
        m_front_next  = m_front_reg;
        m_back_next   = m_back_reg;
        m_count_next  = m_count_reg;
        mem_we        = 1'b0;
        mem_waddr     = head_reg;
        mem_wdata     = key_reg;
        mem_raddr     = head_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next    = s_cmd;
                    key_next    = VALUE_BITS'(s_value);
                    status_next = ST_OK;
                    found_next  = 1'b0;
                    state_next  = S_EXEC;
                end
            end

            S_EXEC: begin
                state_next = S_RD_FRONT;
                unique case (cmd_reg)
                    CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                        if (is_full) begin
                            status_next = ST_FULL;
                        end else begin
                            mem_we     = 1'b1;
                            count_next = CNT_W'(count_reg + 1'b1);
                            if (cmd_reg == CMD_PUSH_FRONT) begin
                                mem_waddr = slot_dec(head_reg);
                                head_next = slot_dec(head_reg);
                            end else begin
                                mem_waddr = slot_add(head_reg, SLOT_W'(count_reg));
                            end
                        end
                    end
                    CMD_POP_FRONT, CMD_POP_BACK: begin
                        if (is_empty) begin
                            status_next = ST_EMPTY;
                        end else begin
                            count_next = CNT_W'(count_reg - 1'b1);
                            if (cmd_reg == CMD_POP_FRONT) begin
                                head_next = slot_inc(head_reg);
                            end
                        end
                    end
                    CMD_CONTAINS, CMD_REMOVE: begin
                        if (is_empty) begin
                            status_next = ST_EMPTY;
                        end else begin
                            // Read the front entry; the scan compares it next cycle.
                            mem_raddr  = head_reg;
                            pos_next   = '0;
                            slot_next  = head_reg;
                            state_next = S_SCAN;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // Read data holds the entry at pos_reg; the next one is requested.
            S_SCAN: begin
                mem_raddr = slot_inc(slot_reg);
                if (mem_rdata == key_reg) begin
                    found_next = 1'b1;
                    state_next = (cmd_reg == CMD_REMOVE) ? S_SHIFT : S_RD_FRONT;
                end else if (at_last) begin
                    state_next = S_RD_FRONT;
                end else begin
                    pos_next  = CNT_W'(pos_reg + 1'b1);
                    slot_next = slot_inc(slot_reg);
                end
            end

            // Move each later entry one place toward the front.
            S_SHIFT: begin
                mem_raddr = slot_inc(slot_inc(slot_reg));
                if (at_last) begin
                    count_next = CNT_W'(count_reg - 1'b1);
                    state_next = S_RD_FRONT;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = slot_reg;
                    mem_wdata = mem_rdata;
                    pos_next  = CNT_W'(pos_reg + 1'b1);
                    slot_next = slot_inc(slot_reg);
                end
            end

            S_RD_FRONT: begin
                mem_raddr  = head_reg;
                state_next = S_RD_BACK;
            end

            S_RD_BACK: begin
                front_next = mem_rdata;
                mem_raddr  = back_slot;
                state_next = S_DONE;
            end

            // Back value stays on the read port until the output register is free.
            S_DONE: begin
                mem_raddr = back_slot;
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_found_next  = found_reg;
                    m_front_next  = is_empty ? '0 : to_word(front_reg);
                    m_back_next   = is_empty ? '0 : to_word(mem_rdata);
                    m_count_next  = count_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working and output payload.
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        pos_reg      <= pos_next;
        slot_reg     <= slot_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        front_reg    <= front_next;
        m_status_reg <= m_status_next;
        m_found_reg  <= m_found_next;
        m_front_reg  <= m_front_next;
        m_back_reg   <= m_back_next;
        m_count_reg  <= m_count_next;
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_found       = m_found_reg;
    assign m_front_value = m_front_reg;
    assign m_back_value  = m_back_reg;
    assign m_count       = m_count_reg;

endmodule

### design/dqvs_store.sv
// ----------------------------------------------------------------------------
// dqvs_store: ring storage of the deque
// Single write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dqvs_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

### design/dqvs_checker.sv
// ----------------------------------------------------------------------------
// dqvs_checker: port-level checks for the deque with value search
// Watches the result channel and its relation to the reported count.
// ----------------------------------------------------------------------------
module dqvs_checker
    import dqvs_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [STATUS_W-1:0]           m_status,
    input logic                          m_found,
    input logic signed [WORD_W-1:0]      m_front_value,
    input logic signed [WORD_W-1:0]      m_back_value,
    input logic [$clog2(CAPACITY+1)-1:0] m_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // A stalled result word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_count) && $stable(m_status)
            && $stable(m_front_value) && $stable(m_back_value) && $stable(m_found))
        else $error("result word changed while stalled");

    // An empty deque reports zero front and back values.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_count == '0 |-> m_front_value == '0 && m_back_value == '0)
        else $error("empty deque with nonzero front or back value");

    // An empty error only happens with nothing held, and never finds.
    a_empty_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_EMPTY |-> m_count == '0 && !m_found)
        else $error("empty error with entries held");

    // A full error only happens at capacity.
    a_full_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FULL |-> m_count == CNT_W'(CAPACITY) && !m_found)
        else $error("full error below capacity");

    // The count never exceeds capacity.
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_count <= CNT_W'(CAPACITY))
        else $error("count above capacity");

endmodule

bind deque_with_value_search dqvs_checker #(
    .CAPACITY (CAPACITY)
) u_dqvs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_found       (m_found),
    .m_front_value (m_front_value),
    .m_back_value  (m_back_value),
    .m_count       (m_count)
);

### tb/sv/deque_with_value_search_tb.sv
// ----------------------------------------------------------------------------
// deque_with_value_search_tb: self-checking bench for the deque with search
// Drives command words on the s_ channel and checks every result word on the
// m_ channel against a cycle-free model of the deque kept in this bench.
// A short table covers the empty errors, unused codes, extreme values and the
// remove cases; random traffic then grows, drains and fills the deque under
// random stalls on both channels, one long output stall and a full drain.
// ----------------------------------------------------------------------------
module deque_with_value_search_tb
    import dqvs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 64;
    localparam int COUNT_W      = $clog2(DEPTH + 1);
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 10;
    localparam int STALL_LIMIT  = 5000;
    localparam int MAX_REPORTS  = 10;
    localparam int RECENT_N     = 16;

    // Command codes the block treats as no-ops.
    localparam logic [CMD_W-1:0] CMD_NOP_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_NOP_7 = 3'd7;

    localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic [WORD_W-1:0] WORD_NEG = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [WORD_W-1:0]   front;
        logic [WORD_W-1:0]   back;
        logic [COUNT_W-1:0]  count;
    } deque_result_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] value;
        logic              fixed;
        deque_result_t     res;
    } cmd_row_t;

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN, MIX_FILL} mix_t;

    logic                       aclk    = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [CMD_W-1:0]           s_cmd   = '0;
    logic signed [WORD_W-1:0]   s_value = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [STATUS_W-1:0]        m_status;
    logic                       m_found;
    logic signed [WORD_W-1:0]   m_front_value;
    logic signed [WORD_W-1:0]   m_back_value;
    logic [COUNT_W-1:0]         m_count;

    // Typed expectation travelling with the word on offer, if the row has one.
    logic          word_fixed     = 1'b0;
    deque_result_t word_fixed_res = '0;

    // Deque contents as this bench sees them.
    logic [WORD_W-1:0] ring_store [DEPTH];
    int                head_pos   = 0;
    int                fill_level = 0;

    deque_result_t     awaited_q [$];
    int                failures      = 0;
    int                results_seen  = 0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    bit                hold_req      = 1'b0;
    logic [WORD_W-1:0] recent_vals [RECENT_N];
    int                recent_wr     = 0;

    // Directed rows; a set fixed bit means the result is typed in here.
    cmd_row_t directed_rows [21] = '{
        '{CMD_POP_FRONT,  32'd0,        1'b1, '{ST_EMPTY, 1'b0, 32'd0, 32'd0, 7'd0}},
        '{CMD_POP_BACK,   32'd0,        1'b1, '{ST_EMPTY, 1'b0, 32'd0, 32'd0, 7'd0}},
        '{CMD_CONTAINS,   32'd5,        1'b1, '{ST_EMPTY, 1'b0, 32'd0, 32'd0, 7'd0}},
        '{CMD_REMOVE,     32'd5,        1'b1, '{ST_EMPTY, 1'b0, 32'd0, 32'd0, 7'd0}},
        '{CMD_NOP_6,      32'hDEADBEEF, 1'b1, '{ST_OK, 1'b0, 32'd0, 32'd0, 7'd0}},
        '{CMD_PUSH_BACK,  WORD_MAX,     1'b1, '{ST_OK, 1'b0, WORD_MAX, WORD_MAX, 7'd1}},
        '{CMD_PUSH_FRONT, WORD_MIN,     1'b1, '{ST_OK, 1'b0, WORD_MIN, WORD_MAX, 7'd2}},
        '{CMD_PUSH_BACK,  WORD_NEG,     1'b1, '{ST_OK, 1'b0, WORD_MIN, WORD_NEG, 7'd3}},
        '{CMD_PUSH_FRONT, 32'd0,        1'b0, '0},
        '{CMD_CONTAINS,   WORD_MIN,     1'b0, '0},
        '{CMD_CONTAINS,   32'd12345,    1'b0, '0},
        '{CMD_REMOVE,     32'd12345,    1'b0, '0},
        '{CMD_NOP_7,      WORD_NEG,     1'b0, '0},
        '{CMD_REMOVE,     WORD_MIN,     1'b0, '0},
        '{CMD_PUSH_BACK,  32'd0,        1'b0, '0},
        '{CMD_REMOVE,     32'd0,        1'b0, '0},
        '{CMD_POP_FRONT,  32'h1234_5678, 1'b0, '0},
        '{CMD_POP_BACK,   32'd0,        1'b0, '0},
        '{CMD_REMOVE,     WORD_NEG,     1'b0, '0},
        '{CMD_PUSH_FRONT, 32'h5555_AAAA, 1'b0, '0},
        '{CMD_POP_FRONT,  32'd0,        1'b0, '0}
    };

    deque_with_value_search #(
        .CAPACITY   (DEPTH),
        .VALUE_BITS (WORD_W)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found       (m_found),
        .m_front_value (m_front_value),
        .m_back_value  (m_back_value),
        .m_count       (m_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one command to the bench's copy of the deque and return the
    // result word the block should produce for it.
    function automatic deque_result_t step_deque(input logic [CMD_W-1:0] cmd,
                                                 input logic [WORD_W-1:0] val);
        deque_result_t res;
        int            hit;
        res = '0;
        res.status = ST_OK;
        hit = -1;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (fill_level >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    if (cmd == CMD_PUSH_FRONT) begin
                        head_pos = (head_pos + DEPTH - 1) % DEPTH;
                        ring_store[head_pos] = val;
                    end else begin
                        ring_store[(head_pos + fill_level) % DEPTH] = val;
                    end
                    fill_level++;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (fill_level == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    if (cmd == CMD_POP_FRONT)
                        head_pos = (head_pos + 1) % DEPTH;
                    fill_level--;
                end
            end
            CMD_CONTAINS, CMD_REMOVE: begin
                if (fill_level == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    for (int i = 0; i < fill_level && hit < 0; i++) begin
                        if (ring_store[(head_pos + i) % DEPTH] == val)
                            hit = i;
                    end
                    if (hit >= 0) begin
                        res.found = 1'b1;
                        // Removal closes the gap by moving later entries forward.
                        if (cmd == CMD_REMOVE) begin
                            for (int k = hit; k + 1 < fill_level; k++) begin
                                ring_store[(head_pos + k) % DEPTH] =
                                    ring_store[(head_pos + k + 1) % DEPTH];
                            end
                            fill_level--;
                        end
                    end
                end
            end
            default: ;
        endcase
        if (fill_level != 0) begin
            res.front = ring_store[head_pos];
            res.back  = ring_store[(head_pos + fill_level - 1) % DEPTH];
        end
        res.count = COUNT_W'(fill_level);
        return res;
    endfunction

    // Command mix per traffic profile.
    function automatic logic [CMD_W-1:0] pick_cmd(input mix_t mix);
        int   r;
        int   push_pct;
        int   pop_pct;
        int   search_pct;
        logic coin;
        r = $urandom_range(99);
        coin = 1'($urandom_range(1));
        case (mix)
            MIX_GROW:   begin push_pct = 85;  pop_pct = 6;  search_pct = 7;  end
            MIX_SHRINK: begin push_pct = 15;  pop_pct = 45; search_pct = 35; end
            MIX_FILL:   begin push_pct = 100; pop_pct = 0;  search_pct = 0;  end
            default:    begin push_pct = 40;  pop_pct = 30; search_pct = 26; end
        endcase
        if (r < push_pct)
            return coin ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        else if (r < push_pct + pop_pct)
            return coin ? CMD_POP_BACK : CMD_POP_FRONT;
        else if (r < push_pct + pop_pct + search_pct)
            return coin ? CMD_REMOVE : CMD_CONTAINS;
        else
            return coin ? CMD_NOP_7 : CMD_NOP_6;
    endfunction

    // Values lean toward small numbers and recently pushed ones so that
    // searches hit and duplicates appear; the rest are extremes or random.
    function automatic logic [WORD_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return WORD_W'($urandom_range(15));
        else if (r < 55)
            return recent_vals[$urandom_range(RECENT_N - 1)];
        else if (r < 63) begin
            case ($urandom_range(3))
                0:       return WORD_MAX;
                1:       return WORD_MIN;
                2:       return WORD_NEG;
                default: return '0;
            endcase
        end else
            return $urandom;
    endfunction

    task automatic log_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // Offer one word, idling first at random, and return at the edge that
    // accepts it.
    task automatic offer(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] val,
                         input logic fixed, input deque_result_t fixed_res);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_cmd          <= cmd;
        s_value        <= val;
        word_fixed     <= fixed;
        word_fixed_res <= fixed_res;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic run_mix(input mix_t mix, input int n);
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] val;
        for (int i = 0; i < n; i++) begin
            cmd = pick_cmd(mix);
            val = pick_value();
            if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK) begin
                recent_vals[recent_wr] = val;
                recent_wr = (recent_wr + 1) % RECENT_N;
            end
            offer(cmd, val, 1'b0, '0);
        end
    endtask

    // Random segments pick at random among growing, shrinking and even traffic.
    task automatic run_random(input int n);
        int   left;
        int   seg;
        mix_t mix;
        left = n;
        while (left > 0) begin
            mix = mix_t'($urandom_range(2));
            seg = $urandom_range(20, 100);
            if (seg > left)
                seg = left;
            run_mix(mix, seg);
            left -= seg;
        end
    endtask

    // Stop offering and wait until every result has come back.
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (awaited_q.size() != 0);
    endtask

    // Predict at each accepted command word and check each result word.
    always @(posedge aclk) begin
        deque_result_t want;
        deque_result_t got;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                want = step_deque(s_cmd, s_value);
                awaited_q.push_back(word_fixed ? word_fixed_res : want);
            end
            if (m_valid && m_ready) begin
                got = '{m_status, m_found, m_front_value, m_back_value, m_count};
                if (awaited_q.size() == 0) begin
                    log_failure($sformatf("result %0d arrived with nothing expected",
                                          results_seen));
                end else begin
                    want = awaited_q.pop_front();
                    if (got !== want)
                        log_failure($sformatf(
                            {"result %0d mismatch (exp/got): status %0d/%0d found %0d/%0d",
                             " front %h/%h back %h/%h count %0d/%0d"},
                            results_seen, want.status, got.status, want.found, got.found,
                            want.front, got.front, want.back, got.back,
                            want.count, got.count));
                end
                results_seen++;
            end
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Give up when neither channel has moved a word for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("deque_with_value_search_tb: errors");
        $finish;
    end

    // Stimulus sequence.
    initial begin
        foreach (recent_vals[i])
            recent_vals[i] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 36;
        recv_idle_pct = 79;
        foreach (directed_rows[i])
            offer(directed_rows[i].cmd, directed_rows[i].value,
                  directed_rows[i].fixed, directed_rows[i].res);

        // Fill past capacity, then stall the output while commands keep coming.
        run_mix(MIX_FILL, 70);
        hold_req = 1'b1;
        run_mix(MIX_EVEN, 30);
        settle();
        run_random(250);

        send_idle_pct = 79;
        recv_idle_pct = 36;
        run_random(350);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(350);

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0)
            $display("deque_with_value_search_tb: clean");
        else
            $display("deque_with_value_search_tb: errors");
        $finish;
    end

endmodule
